FILE: rtl/gbts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared widths, operation and status codes, and beat types for the gap
// buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 11;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [ST_W-1:0]   status;
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  length;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/gbts_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface gbts_req_if;
  import gbts_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_in;
  logic [POS_W-1:0]  position;

  modport source (output valid, output operation, output char_in, output position,
                  input ready);
  modport sink   (input valid, input operation, input char_in, input position,
                  output ready);
endinterface

interface gbts_rsp_if;
  import gbts_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] read_char;
  logic [ST_W-1:0]   status;
  logic [POS_W-1:0]  cursor;
  logic [POS_W-1:0]  length;

  modport source (output valid, output read_char, output status, output cursor,
                  output length, input ready);
  modport sink   (input valid, input read_char, input status, input cursor,
                  input length, output ready);
endinterface
`default_nettype wire

FILE: rtl/gap_buffer_text_store.sv
`default_nettype none
// Insert, delete and rejected commands produce their result directly; a read
// first registers the byte from the text memory, and a move first copies each
// of the d bytes between the old and new cursor across the gap. One command at
// a time; a move copies one byte per cycle through the text memory. Synchronous
// reset empties the buffer and puts the cursor at zero; the text memory keeps
// its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Fixed-capacity gap buffer for one line of text, with a registered result
// stage that lets a new command in while a result beat waits.
// ----------------------------------------------------------------------------
module gap_buffer_text_store #(
  parameter int unsigned CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gbts_req_if.sink   req,
  gbts_rsp_if.source rsp
);
  import gbts_pkg::*;

  req_t req_data;
  rsp_t core_res;
  rsp_t rsp_data;
  logic core_idle;
  logic core_valid;
  logic core_ready;
  logic start;
  logic rsp_valid;

  assign req_data.operation = req.operation;
  assign req_data.char_in   = req.char_in;
  assign req_data.position  = req.position;
  assign req.ready          = core_idle;
  assign start              = req.valid && core_idle;
  assign core_ready         = !rsp_valid || rsp.ready;

  gbts_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req_data),
    .idle      (core_idle),
    .res_valid (core_valid),
    .res_ready (core_ready),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (core_ready) begin
      rsp_valid <= core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_ready && core_valid) begin
      rsp_data <= core_res;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_char = rsp_data.read_char;
  assign rsp.status    = rsp_data.status;
  assign rsp.cursor    = rsp_data.cursor;
  assign rsp.length    = rsp_data.length;

endmodule
`default_nettype wire

FILE: rtl/gbts_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_core
// Text memory and its sequencer: edits at the gap, reads past the gap and
// gap moves as a pipelined read/write copy loop, one byte per cycle.
// ----------------------------------------------------------------------------
module gbts_core #(
  parameter int unsigned CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gbts_pkg::req_t req,
  output logic          idle,
  output logic          res_valid,
  input  logic          res_ready,
  output gbts_pkg::rsp_t res
);
  import gbts_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOVE = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state;
  logic [CW-1:0]     gap_start;
  logic [CW-1:0]     free_count;
  logic [CW-1:0]     text_length;
  logic [CW-1:0]     target;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_ptr;
  logic [CW-1:0]     wr_ptr;
  logic              dir_left;
  logic              pend;
  logic [ST_W-1:0]   status;
  logic [CHAR_W-1:0] read_char;

  logic [CHAR_W-1:0] mem [CAPACITY];
  logic [CHAR_W-1:0] mem_q;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;
  logic [CHAR_W-1:0] mem_wd;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] len_ext;
  logic [PW-1:0] gs_ext;
  logic          pos_lt_gs;
  logic [CW-1:0] pos_cw;
  logic [CW-1:0] read_addr;

  assign pos_ext   = PW'(req.position);
  assign len_ext   = PW'(text_length);
  assign gs_ext    = PW'(gap_start);
  assign pos_lt_gs = pos_ext < gs_ext;
  assign pos_cw    = CW'(req.position);
  assign read_addr = pos_lt_gs ? pos_cw : pos_cw + free_count;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = gap_start[AW-1:0];
    mem_wd = req.char_in;
    mem_re = 1'b0;
    mem_ra = read_addr[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (start && req.operation == OP_INSERT && free_count != '0) begin
          mem_we = 1'b1;
        end
        if (start && req.operation == OP_READ) begin
          mem_re = 1'b1;
        end
      end
      S_MOVE: begin
        if (pend) begin
          mem_we = 1'b1;
          mem_wa = wr_ptr[AW-1:0];
          mem_wd = mem_q;
        end
        if (count != '0) begin
          mem_re = 1'b1;
          mem_ra = rd_ptr[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      gap_start   <= '0;
      free_count  <= CW'(CAPACITY);
      text_length <= '0;
      pend        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            read_char <= '0;
            status    <= ST_OK;
            state     <= S_DONE;
            case (req.operation)
              OP_INSERT: begin
                if (free_count == '0) begin
                  status <= ST_FULL;
                end else begin
                  gap_start   <= gap_start + 1'b1;
                  free_count  <= free_count - 1'b1;
                  text_length <= text_length + 1'b1;
                end
              end
              OP_DELETE: begin
                if (gap_start == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  gap_start   <= gap_start - 1'b1;
                  free_count  <= free_count + 1'b1;
                  text_length <= text_length - 1'b1;
                end
              end
              OP_MOVE: begin
                if (pos_ext > len_ext) begin
                  status <= ST_RANGE;
                end else begin
                  target   <= pos_cw;
                  dir_left <= pos_lt_gs;
                  pend     <= 1'b0;
                  state    <= S_MOVE;
                  if (pos_lt_gs) begin
                    count  <= gap_start - pos_cw;
                    rd_ptr <= gap_start - 1'b1;
                    wr_ptr <= gap_start + free_count - 1'b1;
                  end else begin
                    count  <= pos_cw - gap_start;
                    rd_ptr <= gap_start + free_count;
                    wr_ptr <= gap_start;
                  end
                end
              end
              default: begin
                if (pos_ext >= len_ext) begin
                  status <= ST_RANGE;
                end else begin
                  state <= S_READ;
                end
              end
            endcase
          end
        end
        S_MOVE: begin
          pend <= count != '0;
          if (count != '0) begin
            count  <= count - 1'b1;
            rd_ptr <= dir_left ? rd_ptr - 1'b1 : rd_ptr + 1'b1;
          end
          if (pend) begin
            wr_ptr <= dir_left ? wr_ptr - 1'b1 : wr_ptr + 1'b1;
          end
          if (count == '0 && !pend) begin
            gap_start <= target;
            state     <= S_DONE;
          end
        end
        S_READ: begin
          read_char <= mem_q;
          state     <= S_DONE;
        end
        default: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign idle          = state == S_IDLE;
  assign res_valid     = state == S_DONE;
  assign res.read_char = read_char;
  assign res.status    = status;
  assign res.cursor    = POS_W'(gap_start);
  assign res.length    = POS_W'(text_length);

endmodule
`default_nettype wire

FILE: dv/gap_buffer_text_store_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gap_buffer_text_store_test
// Drives edit commands (insert, delete, move, read) into the gap buffer under
// random sender bursts and receiver stalls, predicts every result beat from a
// behavioural copy of the line, and compares each field in order. Covers the
// empty and full buffer, range errors and long gap moves over a full line.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_test;
  import gbts_pkg::*;

  localparam int unsigned LINE_CAP = CAPACITY_DEF;
  localparam int unsigned POS_MAX  = (1 << POS_W) - 1;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLD_AT    = 150;
  localparam int unsigned HOLD_LEN   = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gbts_req_if req_ch ();
  gbts_rsp_if rsp_ch ();

  gap_buffer_text_store #(
    .CAPACITY(LINE_CAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // behavioural copy of the line
  logic [CHAR_W-1:0] line_mem [LINE_CAP];
  int unsigned line_cursor;
  int unsigned line_free;
  int unsigned line_len;

  req_t edit_cmds [$];
  rsp_t pending_outcomes [$];

  int unsigned failures;
  int unsigned results_seen;
  int unsigned idle_cycles;
  bit          cmd_taken;

  // stimulus-side view of length and cursor, used only in command generation
  int unsigned gen_len;
  int unsigned gen_cur;

  function automatic rsp_t apply_edit(req_t c);
    rsp_t        r;
    int unsigned right;
    int unsigned idx;
    int unsigned tgt;
    r = '0;
    r.status = ST_OK;
    tgt = 32'(c.position);
    case (c.operation)
      OP_INSERT: begin
        if (line_free == 0) begin
          r.status = ST_FULL;
        end else begin
          line_mem[line_cursor] = c.char_in;
          line_cursor++;
          line_free--;
          line_len++;
        end
      end
      OP_DELETE: begin
        if (line_cursor == 0) begin
          r.status = ST_EMPTY;
        end else begin
          line_cursor--;
          line_free++;
          line_len--;
        end
      end
      OP_MOVE: begin
        if (tgt > line_len) begin
          r.status = ST_RANGE;
        end else begin
          right = line_cursor + line_free;
          while (line_cursor > tgt) begin
            right--;
            line_cursor--;
            line_mem[right] = line_mem[line_cursor];
          end
          while (line_cursor < tgt) begin
            line_mem[line_cursor] = line_mem[right];
            right++;
            line_cursor++;
          end
        end
      end
      default: begin
        if (tgt >= line_len) begin
          r.status = ST_RANGE;
        end else begin
          idx = (tgt < line_cursor) ? tgt : tgt + line_free;
          r.read_char = line_mem[idx];
        end
      end
    endcase
    r.cursor = POS_W'(line_cursor);
    r.length = POS_W'(line_len);
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  task automatic add_cmd(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, int unsigned pos);
    req_t c;
    c.operation = op;
    c.char_in   = ch;
    c.position  = POS_W'(pos);
    edit_cmds.push_back(c);
    case (op)
      OP_INSERT: begin
        if (gen_len < LINE_CAP) begin
          gen_len++;
          gen_cur++;
        end
      end
      OP_DELETE: begin
        if (gen_cur > 0) begin
          gen_len--;
          gen_cur--;
        end
      end
      OP_MOVE: begin
        if (pos <= gen_len) gen_cur = pos;
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_move_pos();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p < 16) return $urandom_range(0, gen_len);
    if (p < 18) return gen_len + 1;
    return $urandom_range(0, POS_MAX);
  endfunction

  function automatic int unsigned pick_read_pos();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p < 16 && gen_len > 0) return $urandom_range(0, gen_len - 1);
    if (p < 18) return gen_len;
    return $urandom_range(0, POS_MAX);
  endfunction

  task automatic add_random(int unsigned n, int unsigned len_cap);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if (gen_len >= len_cap && len_cap < LINE_CAP) begin
          add_cmd(OP_DELETE, CHAR_W'($urandom), 0);
        end else begin
          add_cmd(OP_INSERT, CHAR_W'($urandom_range(0, 255)), $urandom_range(0, POS_MAX));
        end
      end else if (r < 55) begin
        add_cmd(OP_DELETE, CHAR_W'($urandom), $urandom_range(0, POS_MAX));
      end else if (r < 75) begin
        add_cmd(OP_MOVE, CHAR_W'($urandom), pick_move_pos());
      end else begin
        add_cmd(OP_READ, CHAR_W'($urandom), pick_read_pos());
      end
    end
  endtask

  task automatic fill_line();
    int unsigned r;
    while (gen_len < LINE_CAP) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        add_cmd(OP_INSERT, CHAR_W'($urandom_range(0, 255)), $urandom_range(0, POS_MAX));
      end else if (r < 90) begin
        add_cmd(OP_MOVE, CHAR_W'($urandom), $urandom_range(0, gen_len));
      end else begin
        add_cmd(OP_READ, CHAR_W'($urandom), pick_read_pos());
      end
    end
  endtask

  // sender: bursts of random length with random gaps
  int unsigned burst_left;
  int unsigned pause_left;
  req_t        next_cmd;

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || cmd_taken) begin
      if (pause_left > 0) begin
        pause_left--;
        req_ch.valid <= 1'b0;
      end else if (edit_cmds.size() > 0) begin
        next_cmd = edit_cmds.pop_front();
        req_ch.operation <= next_cmd.operation;
        req_ch.char_in   <= next_cmd.char_in;
        req_ch.position  <= next_cmd.position;
        req_ch.valid     <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 8);
          pause_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern picked at random from four, plus one long hold-off
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  bit          hold_done;
  bit          toggle;

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = 64;
      end
      mode_left--;
      toggle = !toggle;
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= toggle;
      endcase
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin : observe
    req_t cmd;
    rsp_t got;
    rsp_t want;
    cmd_taken = !rst && req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        got.read_char = rsp_ch.read_char;
        got.status    = rsp_ch.status;
        got.cursor    = rsp_ch.cursor;
        got.length    = rsp_ch.length;
        if (pending_outcomes.size() == 0) begin
          failures++;
          $display("%0t: result beat with nothing expected, actual %p", $time, got);
        end else begin
          want = pending_outcomes.pop_front();
          check_field("read_char", 32'(want.read_char), 32'(got.read_char));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("cursor", 32'(want.cursor), 32'(got.cursor));
          check_field("length", 32'(want.length), 32'(got.length));
        end
      end
      if (cmd_taken) begin
        cmd.operation = req_ch.operation;
        cmd.char_in   = req_ch.char_in;
        cmd.position  = req_ch.position;
        pending_outcomes.push_back(apply_edit(cmd));
      end
      if (cmd_taken || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin
    line_cursor = 0;
    line_free   = LINE_CAP;
    line_len    = 0;
    foreach (line_mem[i]) line_mem[i] = '0;

    // directed: empty line, edges of every field, gap skipping on read
    add_cmd(OP_READ,   8'h00, 0);
    add_cmd(OP_DELETE, 8'h00, 0);
    add_cmd(OP_MOVE,   8'h00, 0);
    add_cmd(OP_MOVE,   8'h00, 1);
    add_cmd(OP_MOVE,   8'hFF, POS_MAX);
    add_cmd(OP_INSERT, 8'h00, 0);
    add_cmd(OP_INSERT, 8'hFF, POS_MAX);
    add_cmd(OP_INSERT, 8'hA5, 0);
    add_cmd(OP_INSERT, 8'h5A, 0);
    add_cmd(OP_READ,   8'h00, 0);
    add_cmd(OP_READ,   8'h00, 3);
    add_cmd(OP_READ,   8'h00, 4);
    add_cmd(OP_READ,   8'h00, POS_MAX);
    add_cmd(OP_MOVE,   8'h00, 0);
    add_cmd(OP_INSERT, 8'h41, 0);
    add_cmd(OP_MOVE,   8'h00, 5);
    add_cmd(OP_MOVE,   8'h00, 2);
    add_cmd(OP_READ,   8'h00, 1);
    add_cmd(OP_READ,   8'h00, 2);
    add_cmd(OP_READ,   8'h00, 3);
    add_cmd(OP_DELETE, 8'h00, 0);
    add_cmd(OP_MOVE,   8'h00, 1);
    add_cmd(OP_DELETE, 8'h00, 0);
    add_cmd(OP_DELETE, 8'h00, 0);
    add_cmd(OP_READ,   8'h00, 0);

    add_random(250, 48);

    // full line: rejected inserts, moves across the whole line
    fill_line();
    add_cmd(OP_INSERT, 8'h7E, 0);
    add_cmd(OP_READ,   8'h00, LINE_CAP - 1);
    add_cmd(OP_READ,   8'h00, LINE_CAP);
    add_cmd(OP_MOVE,   8'h00, 0);
    add_cmd(OP_DELETE, 8'h00, 0);
    add_cmd(OP_INSERT, 8'h81, 0);
    add_cmd(OP_READ,   8'h00, 0);
    add_cmd(OP_MOVE,   8'h00, LINE_CAP);
    add_cmd(OP_MOVE,   8'h00, LINE_CAP + 1);
    add_cmd(OP_MOVE,   8'h00, LINE_CAP / 2);
    add_cmd(OP_DELETE, 8'h00, 0);
    add_cmd(OP_INSERT, 8'hC3, 0);
    add_cmd(OP_INSERT, 8'h3C, 0);
    add_random(200, LINE_CAP);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (edit_cmds.size() != 0 || req_ch.valid) @(negedge clk);
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/gbts_pkg.sv
rtl/gbts_if.sv
rtl/gbts_core.sv
rtl/gap_buffer_text_store.sv
dv/gap_buffer_text_store_test.sv
